// ===== design/rcwcp_pkg.sv =====
// rcwcp_pkg: widths, reset values, register indexes and the quarter-wave cosine ROM
// contents for the wall column projector. No dependencies.
package rcwcp_pkg;

  // field widths
  localparam int COL_W    = 10;
  localparam int DIST_W   = 20;
  localparam int ANGLE_BITS = 12;
  localparam int TILE_W   = 13;
  localparam int PLANE_W  = 20;
  localparam int COLOR_W  = 32;
  localparam int HEIGHT_W = 16;
  localparam int TOP_W    = 9;
  localparam int BOT_W    = 10;
  localparam int COS_W    = 16;

  // screen geometry
  localparam int SCREEN_HEIGHT = 512;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;

  // stream packing
  localparam int IN_FIELDS_W  = COL_W + DIST_W + 2 * ANGLE_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COL_W + HEIGHT_W + TOP_W + BOT_W + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // config port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DISTANCE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_COLOR   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_COLOR = CFG_IDX_W'(3);

  localparam logic [TILE_W-1:0]  TILE_SIZE_RST   = TILE_W'(64);
  localparam logic [PLANE_W-1:0] PLANE_DIST_RST  = PLANE_W'(14189);
  localparam logic [COLOR_W-1:0] VERT_COLOR_RST  = 32'hFFCC_CCCC;
  localparam logic [COLOR_W-1:0] HORZ_COLOR_RST  = 32'hFFFF_FFFF;

  // quarter-wave cosine table, Q1.15
  localparam int COS_AW    = ANGLE_BITS - 2;
  localparam int COS_DEPTH = 1 << COS_AW;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd182, 64'd132, 64'd90, 64'd56,
                                             64'd30, 64'd12, 64'd2};

  typedef logic [COS_W-1:0] cos_tab_t [COS_DEPTH];

  // Horner Taylor series to x^14 with truncating Q30 steps, rounded to Q1.15.
  // Evaluated at elaboration only.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] c;
    for (int k = 0; k < COS_DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30) / COS_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 7; i++) begin
        sub = ((x2 * t) >> 30) / TAYLOR_DIV[i];
        t   = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      end
      c = (t + (64'd1 << 14)) >> 15;
      if (c > 64'd32768) begin
        c = 64'd32768;
      end
      tab[k] = c[COS_W-1:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // beat payload that rides the whole pipe
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [COLOR_W-1:0] color;
  } pay_t;

endpackage

// ===== design/raycast_wall_column_projector_top.sv =====
// Wall column projector: fisheye correction, pipelined height division and span clamp.
// Depends on rcwcp_pkg (widths, register indexes, cosine ROM contents).
//
// Usage
//   s_axis: one beat per screen column. tdata = column, ray_distance (Q16.4),
//     ray angle, player_angle from bit 0 up; tuser = hit_vertical.
//   m_axis: one beat per input beat, same order. tdata = out_column,
//     height, top_row, bottom_row, fill_color from bit 0 up.
//   cfg: write channel (index, data), always ready. Write only while no beat
//     is in flight; index 0 tile size, 1 plane_distance, 2 vertical_color,
//     3 horizontal_color, anything else is dropped.
// Timing
//   13 register stages: angle/ROM address, cosine ROM read, distance x cosine
//   multiply, saturation compare, eight radix-2 divider stages (two quotient
//   bits each), span clamp. Each beat passes these stages in that order.
//   Throughput one beat per clock while m_axis is not stalled.
// Reset
//   rst (sync, active high) empties the pipe and reloads register defaults.
//   The cosine table is a constant ROM and needs no fill.
// Backpressure
//   Each stage has its own valid bit and loads whenever m_axis is ready or it
//   or anything after it is empty, so bubbles close up and s_axis_tready stays
//   high until every stage holds a beat while m_axis is stalled.
module raycast_wall_column_projector_top (
  input  logic                                clk,
  input  logic                                rst,
  // column, ray_distance, ray angle, player_angle (bit 0 up), zero pad
  input  logic [rcwcp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                s_axis_tuser,  // hit_vertical
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // out_column, height, top_row, bottom_row, fill_color (bit 0 up), zero pad
  output logic [rcwcp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcwcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcwcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rcwcp_pkg::*;

  localparam int QUO_W    = HEIGHT_W;
  localparam int REM_W    = DIST_W;
  localparam int NUM_W    = TILE_W + PLANE_W;
  localparam int DIV_BITS = 2;
  localparam int DIV_STG  = QUO_W / DIV_BITS;
  localparam int ST_ANG   = 0;
  localparam int ST_ROM   = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_SAT   = 3;
  localparam int ST_DIV0  = 4;
  localparam int ST_OUT   = ST_DIV0 + DIV_STG;
  localparam int NSTG     = ST_OUT + 1;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  // ---------------- config registers ----------------
  logic [TILE_W-1:0]  tile_units;
  logic [PLANE_W-1:0] plane_distance;
  logic [COLOR_W-1:0] vertical_color;
  logic [COLOR_W-1:0] horizontal_color;
  logic [NUM_W-1:0]   num;  // tile_units * plane_distance, the dividend

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_units       <= TILE_SIZE_RST;
      plane_distance   <= PLANE_DIST_RST;
      vertical_color   <= VERT_COLOR_RST;
      horizontal_color <= HORZ_COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TILE_SIZE:        tile_units       <= cfg_data[TILE_W-1:0];
        CFG_PLANE_DISTANCE:   plane_distance   <= cfg_data[PLANE_W-1:0];
        CFG_VERTICAL_COLOR:   vertical_color   <= cfg_data[COLOR_W-1:0];
        CFG_HORIZONTAL_COLOR: horizontal_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // the user keeps config static while beats fly; the block does not enforce it; refreshed every clock
  always_ff @(posedge clk) begin
    num <= NUM_W'(tile_units) * NUM_W'(plane_distance);
  end

  // ---------------- pipe control ----------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] en;

  assign vld_in = {vld[NSTG-2:0], s_axis_tvalid};

  // stage i may load unless it and every stage after it are full and stalled
  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      en[i] = m_axis_tready ||
              ((vld | ((NSTG'(1) << i) - NSTG'(1))) != {NSTG{1'b1}});
    end
  end

  assign s_axis_tready = en[ST_ANG];
  assign m_axis_tvalid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // column and colour ride along
  pay_t pay    [NSTG];
  pay_t pay_in [NSTG];

  always_comb begin
    pay_in[0].column = s_axis_tdata[COL_W-1:0];
    pay_in[0].color  = s_axis_tuser ? vertical_color : horizontal_color;
    for (int i = 1; i < NSTG; i++) begin
      pay_in[i] = pay[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (en[i]) begin
        pay[i] <= pay_in[i];
      end
    end
  end

  // ---------------- stage 0: angle difference -> ROM address ----------------
  logic [DIST_W-1:0]     in_dist;
  logic [ANGLE_BITS-1:0] in_ray;
  logic [ANGLE_BITS-1:0] in_ply;
  logic [ANGLE_BITS-1:0] diff;
  logic [COS_AW-1:0]     diff_r;
  logic                  odd_quad;

  assign in_dist  = s_axis_tdata[COL_W +: DIST_W];
  assign in_ray   = s_axis_tdata[COL_W + DIST_W +: ANGLE_BITS];
  assign in_ply   = s_axis_tdata[COL_W + DIST_W + ANGLE_BITS +: ANGLE_BITS];
  assign diff     = in_ray - in_ply;
  assign diff_r   = diff[COS_AW-1:0];
  assign odd_quad = diff[COS_AW];

  logic [COS_AW-1:0] a_addr;
  logic              a_zero;   // exact quarter turn: cosine is 0
  logic [DIST_W-1:0] a_dist;

  always_ff @(posedge clk) begin
    if (en[ST_ANG]) begin
      // odd quadrants mirror: QUARTER - r, taken mod QUARTER
      a_addr <= odd_quad ? (COS_AW'(0) - diff_r) : diff_r;
      a_zero <= odd_quad && (diff_r == '0);
      a_dist <= in_dist;
    end
  end

  // ---------------- stage 1: cosine ROM ----------------
  logic [COS_W-1:0]  b_cos;
  logic [DIST_W-1:0] b_dist;

  always_ff @(posedge clk) begin
    if (en[ST_ROM]) begin
      b_cos  <= a_zero ? '0 : COS_TAB[a_addr];
      b_dist <= a_dist;
    end
  end

  // ---------------- stage 2: perpendicular distance ----------------
  logic [DIST_W+COS_W-1:0] prod;
  logic [REM_W-1:0]        c_perp;

  assign prod = (DIST_W + COS_W)'(b_dist) * (DIST_W + COS_W)'(b_cos);

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      c_perp <= prod[REM_W+COS_W-2:COS_W-1];
    end
  end

  // ---------------- stage 3: saturation test, divider load ----------------
  // quotient > 65535 iff num >> 16 >= perp; also catches perp == 0
  logic [REM_W-1:0] dv_rem  [DIV_STG];
  logic [REM_W-1:0] dv_perp [DIV_STG];
  logic [QUO_W-1:0] dv_lq   [DIV_STG+1];  // dividend bits out top, quotient bits in
  logic             dv_sat  [DIV_STG+1];
  logic             sat_now;

  assign sat_now = REM_W'(num[NUM_W-1:QUO_W]) >= c_perp;

  always_ff @(posedge clk) begin
    if (en[ST_SAT]) begin
      dv_rem[0]  <= sat_now ? '0 : REM_W'(num[NUM_W-1:QUO_W]);
      dv_lq[0]   <= num[QUO_W-1:0];
      dv_perp[0] <= c_perp;
      dv_sat[0]  <= sat_now;
    end
  end

  // ---------------- stages 4..11: restoring divider ----------------
  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    logic [REM_W-1:0] rem_c;
    logic [QUO_W-1:0] lq_c;

    always_comb begin : div_step
      logic [REM_W:0] trial;
      logic           ge;
      rem_c = dv_rem[j];
      lq_c  = dv_lq[j];
      for (int s = 0; s < DIV_BITS; s++) begin
        trial = {rem_c, lq_c[QUO_W-1]};
        ge    = trial >= {1'b0, dv_perp[j]};
        rem_c = ge ? REM_W'(trial - {1'b0, dv_perp[j]}) : trial[REM_W-1:0];
        lq_c  = {lq_c[QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + j]) begin
        dv_lq[j+1]  <= lq_c;
        dv_sat[j+1] <= dv_sat[j];
      end
    end

    if (j < DIV_STG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[ST_DIV0 + j]) begin
          dv_rem[j+1]  <= rem_c;
          dv_perp[j+1] <= dv_perp[j];
        end
      end
    end
  end

  // ---------------- stage 12: height and span clamp ----------------
  logic [HEIGHT_W-1:0]   h_now;
  logic [HEIGHT_W-2:0]   half_now;
  logic                  tall;
  logic [HEIGHT_W-1:0]   o_height;
  logic [TOP_W-1:0]      o_top;
  logic [BOT_W-1:0]      o_bot;

  assign h_now    = dv_sat[DIV_STG] ? {HEIGHT_W{1'b1}} : dv_lq[DIV_STG];
  assign half_now = h_now[HEIGHT_W-1:1];
  assign tall     = half_now >= (HEIGHT_W-1)'(HALF_H);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      o_height <= h_now;
      o_top    <= tall ? '0 : TOP_W'(HALF_H - int'(half_now));
      o_bot    <= tall ? BOT_W'(SCREEN_HEIGHT) : BOT_W'(HALF_H + int'(half_now));
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, pay[ST_OUT].color, o_bot, o_top,
                         o_height, pay[ST_OUT].column};

`ifndef SYNTHESIS
  // an empty output stage never blocks the input side
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_OUT] |-> s_axis_tready)
    else $error("input stalled with output stage empty");

  // an accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[ST_ANG])
    else $error("accepted beat lost at stage 0");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // span never inverted
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> o_bot >= BOT_W'(o_top))
    else $error("bottom_row above top_row");

  // saturated height fills the whole column
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (o_height == {HEIGHT_W{1'b1}}) |->
      (o_top == '0) && (o_bot == BOT_W'(SCREEN_HEIGHT)))
    else $error("saturated height not clamped to full column");
`endif

endmodule
